>>> design/sorted_list_insert_delete_core_defines.svh
// Assertion macros for the sorted list core.
`ifndef SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted list core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted list core: next-cycle check failed");

`endif

>>> design/sli_pkg.sv
// Shared types, sizes and codes of the sorted list core.
package sli_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;
	typedef logic signed [DATA_W-1:0] value_t;

	localparam mode_t MODE_INSERT  = 2'd0;
	localparam mode_t MODE_DELETE  = 2'd1;
	localparam mode_t MODE_READOUT = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_EMPTY     = 2'd3;

endpackage

>>> design/sli_ifs.sv
// Command and response channel interfaces of the sorted list core.
interface sli_cmd_if import sli_pkg::*; ();
	logic   valid;
	logic   ready;
	mode_t  mode;
	value_t operand_value;

	modport source (output valid, output mode, output operand_value, input ready);
	modport sink (input valid, input mode, input operand_value, output ready);
endinterface

interface sli_rsp_if import sli_pkg::*; ();
	logic    valid;
	logic    ready;
	value_t  entry_value;
	status_t status;
	logic    last;

	modport source (output valid, output entry_value, output status, output last, input ready);
	modport sink (input valid, input entry_value, input status, input last, output ready);
endinterface

>>> design/sli_ram.sv
// Generic simple dual-port RAM with registered read.
module sli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/sorted_list_insert_delete_core.sv
// Sorted multiset table: insert, delete and ordered readout over one RAM.
//
// Usage: commands arrive as transactions on cmd (mode, operand_value) and
// results leave as transactions on rsp (entry_value, status, last).
// Insert and delete give one result with last set; a readout gives one
// result per stored entry in ascending signed order, last on the final one,
// or a single result with status empty when the table holds nothing.
// cmd is taken only while the sequencer is idle; a finished result waits in
// the output register, so the next command can be taken meanwhile.
// All work goes through the single entry RAM (one read and one write port,
// registered read):
//   insert: entries above the value are moved up one at a time, then it is
//   written; an empty table takes it directly, a full one gives status full
//   delete: entries are scanned from index 0 to the match and those after it
//   moved down; no match or an empty table gives status not found
//   readout: entries are loaded in order, one per cycle while rsp is not stalled
//   unused mode: a single result with status ok
// The next command can be taken in the cycle after the final result is loaded.
// Reset empties the table at once; no clearing pass is run.
// If rsp is stalled the result is held and the sequencer waits for it.
`include "sorted_list_insert_delete_core_defines.svh"

module sorted_list_insert_delete_core import sli_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	sli_cmd_if.sink  cmd,
	sli_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS_CHK  = 3'd1;
	localparam logic [2:0] S_INS_PUT0 = 3'd2;
	localparam logic [2:0] S_DEL_CHK  = 3'd3;
	localparam logic [2:0] S_DEL_SHF  = 3'd4;
	localparam logic [2:0] S_OUT      = 3'd5;
	localparam logic [2:0] S_RESP     = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_ext;
	value_t           val_q;
	status_t          status_q, status_d;

	logic              rsp_valid_q;
	value_t            rsp_entry_q;
	status_t           rsp_status_q;
	logic              rsp_last_q;

	logic              accept;
	logic              out_free;
	logic              ld_out;
	value_t            ld_entry;
	status_t           ld_status;
	logic              ld_last;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic [DATA_W-1:0] wr_data;
	logic [DATA_W-1:0] rd_data;

	sli_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign idx_ext   = CNT_W'(idx_q);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		status_d  = status_q;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = rd_data;
		ld_out    = 1'b0;
		ld_entry  = '0;
		ld_status = ST_OK;
		ld_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.mode)
						MODE_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
								state_d  = S_RESP;
							end else if (count_q == '0) begin
								wr_en    = 1'b1;
								wr_addr  = '0;
								wr_data  = cmd.operand_value;
								count_d  = count_q + 1'b1;
								status_d = ST_OK;
								state_d  = S_RESP;
							end else begin
								idx_d   = count_q[IDX_W-1:0];
								rd_addr = IDX_W'(count_q - 1'b1);
								state_d = S_INS_CHK;
							end
						end
						MODE_DELETE: begin
							if (count_q == '0) begin
								status_d = ST_NOT_FOUND;
								state_d  = S_RESP;
							end else begin
								idx_d   = '0;
								rd_addr = '0;
								state_d = S_DEL_CHK;
							end
						end
						MODE_READOUT: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								state_d  = S_RESP;
							end else begin
								idx_d   = '0;
								rd_addr = '0;
								state_d = S_OUT;
							end
						end
						default: begin
							status_d = ST_OK;
							state_d  = S_RESP;
						end
					endcase
				end
			end
			// rd_data holds the entry just below idx; shift it up or drop the value in
			S_INS_CHK: begin
				wr_en = 1'b1;
				if ($signed(rd_data) < val_q) begin
					wr_data  = val_q;
					count_d  = count_q + 1'b1;
					status_d = ST_OK;
					state_d  = S_RESP;
				end else begin
					idx_d = idx_q - 1'b1;
					if (idx_q == IDX_W'(1)) begin
						state_d = S_INS_PUT0;
					end else begin
						rd_addr = idx_q - IDX_W'(2);
					end
				end
			end
			S_INS_PUT0: begin
				wr_en    = 1'b1;
				wr_addr  = '0;
				wr_data  = val_q;
				count_d  = count_q + 1'b1;
				status_d = ST_OK;
				state_d  = S_RESP;
			end
			S_DEL_CHK: begin
				if (rd_data == val_q) begin
					if (idx_ext + 1'b1 == count_q) begin
						count_d  = count_q - 1'b1;
						status_d = ST_OK;
						state_d  = S_RESP;
					end else begin
						rd_addr = idx_q + 1'b1;
						state_d = S_DEL_SHF;
					end
				end else if (idx_ext + 1'b1 == count_q) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_RESP;
				end else begin
					idx_d   = idx_q + 1'b1;
					rd_addr = idx_q + 1'b1;
				end
			end
			// rd_data holds the entry above idx; move it down by one
			S_DEL_SHF: begin
				wr_en = 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_ext + 2'd2 == count_q) begin
					count_d  = count_q - 1'b1;
					status_d = ST_OK;
					state_d  = S_RESP;
				end else begin
					rd_addr = idx_q + 2'd2;
				end
			end
			S_OUT: begin
				if (out_free) begin
					ld_out   = 1'b1;
					ld_entry = rd_data;
					ld_last  = (idx_ext + 1'b1 == count_q);
					if (idx_ext + 1'b1 == count_q) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					ld_out    = 1'b1;
					ld_status = status_q;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			if (ld_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		if (accept) begin
			val_q <= cmd.operand_value;
		end
		if (ld_out) begin
			rsp_entry_q  <= ld_entry;
			rsp_status_q <= ld_status;
			rsp_last_q   <= ld_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.entry_value = rsp_entry_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.last        = rsp_last_q;

	`SLI_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SLI_ASSERT_SAME(a_write_busy, clk, arst_n, wr_en, (state_q != S_IDLE) || accept)
	`SLI_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
	`SLI_ASSERT_SAME(a_rsp_entry_ok, clk, arst_n, rsp.valid && (rsp.entry_value != '0), rsp.status == ST_OK)

endmodule
